// ----- hdl/icca_pkg.sv -----
// Package for the idle color crossfade engine: payload structs, action codes,
// register indexes and the controller/datapath command and status structs.
// Depends on nothing.
package icca_pkg;

	localparam logic [1:0] ACT_TICK  = 2'd0;
	localparam logic [1:0] ACT_SET   = 2'd1;
	localparam logic [1:0] ACT_CLEAR = 2'd2;
	localparam logic [1:0] ACT_IDLE  = 2'd3;

	localparam logic [2:0] REG_FADE_TIME   = 3'd0;
	localparam logic [2:0] REG_ATTR_DELAY  = 3'd1;
	localparam logic [2:0] REG_ATTR_CYCLE  = 3'd2;
	localparam logic [2:0] REG_THUMP       = 3'd3;
	localparam logic [2:0] REG_THUMP_GAP   = 3'd4;
	localparam logic [2:0] REG_ATTR_LOW    = 3'd5;
	localparam logic [2:0] REG_ATTR_HIGH   = 3'd6;
	localparam logic [2:0] REG_DEF_COLOR   = 3'd7;

	localparam int CFG_INDEX_W = 4;
	localparam int CFG_DATA_W  = 32;

	typedef struct packed {
		logic [1:0]  action;
		logic [23:0] tint_color;
		logic [31:0] now_ms;
	} in_req_t;

	typedef struct packed {
		logic [23:0] shown_color;
		logic        transmit;
		logic        fading;
		logic        attracting;
	} out_req_t;

	// division unit operand select
	typedef enum logic [1:0] {
		DIV_FADE,
		DIV_CYCLE,
		DIV_THUMP
	} div_sel_t;

	// arithmetic step select
	typedef enum logic [3:0] {
		OP_X2,
		OP_S,
		OP_T,
		OP_MIX_R,
		OP_MIX_G,
		OP_MIX_B,
		OP_Q,
		OP_BRIGHT,
		OP_DIM_R,
		OP_DIM_G,
		OP_DIM_B
	} op_t;

	typedef struct packed {
		logic     latch;
		logic     div_start;
		div_sel_t div_sel;
		logic     op_en;
		op_t      op;
		logic     beat_eval;
		logic     commit;
	} icca_cmd_t;

	typedef struct packed {
		logic [1:0] action;
		logic       fade_active;
		logic       fade_done;
		logic       attr;
		logic       div_busy;
		logic       in_thump;
	} icca_sts_t;

endpackage

// ----- hdl/icca_div.sv -----
// Restoring divider, one quotient bit per cycle, unsigned.
// Used by the datapath for time fractions and phase modulo. Depends on nothing.
module icca_div #(
	parameter int NUM_W = 48,
	parameter int DEN_W = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             busy,
	output logic [NUM_W-1:0] quo,
	output logic [DEN_W-1:0] rem
);
	localparam int CNT_W = $clog2(NUM_W + 1);

	logic [NUM_W-1:0] quo_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DEN_W:0]   trial;
	logic [DEN_W:0]   diff;

	assign trial = {rem_q, quo_q[NUM_W-1]};
	assign diff  = trial - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CNT_W'(NUM_W);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (cnt_q != '0) begin
			if (!diff[DEN_W]) begin
				rem_q <= diff[DEN_W-1:0];
				quo_q <= {quo_q[NUM_W-2:0], 1'b1};
			end else begin
				rem_q <= trial[DEN_W-1:0];
				quo_q <= {quo_q[NUM_W-2:0], 1'b0};
			end
		end
	end

	assign busy = (cnt_q != '0);
	assign quo  = quo_q;
	assign rem  = rem_q;
endmodule

// ----- hdl/icca_datapath.sv -----
// Datapath: registers, state, shared divider and one multiply step per cycle while cmd.op_en is set.
// Depends on icca_pkg and icca_div.
module icca_datapath #(
	parameter int FRACTION_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [icca_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [icca_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  icca_pkg::in_req_t             in_data,
	input  icca_pkg::icca_cmd_t           cmd,
	output icca_pkg::icca_sts_t           sts,
	output icca_pkg::out_req_t            result
);
	localparam int F   = FRACTION_BITS;
	localparam int NW  = 32 + F;
	localparam int FW  = F + 2;
	localparam logic [FW-1:0] ONE  = FW'(1) << F;
	localparam logic [FW-1:0] HALF = FW'(1) << (F - 1);

	logic [15:0] fade_time_q, cycle_q, thump_q, gap_q;
	logic [31:0] delay_q;
	logic [7:0]  low_q, high_q;
	logic [23:0] def_q;

	logic [23:0] from_q, target_q, cached_q, color_q;
	logic [31:0] start_q, last_q;
	logic        active_q, tinted_q, cvalid_q, send_q, attr_q;

	logic [1:0]  act_q;
	logic [23:0] tint_q;
	logic [31:0] now_q;

	logic [FW-1:0] x2_q, s_q, acc_q;
	logic [FW-1:0] x_frac;
	logic [8:0]    t_q;
	logic [15:0]   phase_q;
	logic [15:0]   into_q;
	logic [7:0]    bright_q;
	logic [15:0]   mix_q;

	logic [15:0] fade_len, cyc_len, thump_len;
	logic [31:0] el_fade, el_idle;
	logic [16:0] second;
	logic        div_start;
	logic [NW-1:0] div_num, div_quo;
	logic [15:0]   div_den, div_rem;
	logic          div_busy;

	assign fade_len  = (fade_time_q == '0) ? 16'd1 : fade_time_q;
	assign cyc_len   = (cycle_q == '0) ? 16'd1 : cycle_q;
	assign thump_len = (thump_q == '0) ? 16'd1 : thump_q;
	assign el_fade   = now_q - start_q;
	assign el_idle   = now_q - last_q;
	assign second    = {1'b0, thump_len} + {1'b0, gap_q};

	always_comb begin
		div_num = '0;
		div_den = fade_len;
		case (cmd.div_sel)
			icca_pkg::DIV_FADE: begin
				div_num = (NW'(el_fade) << F) + NW'(fade_len >> 1);
				div_den = fade_len;
			end
			icca_pkg::DIV_CYCLE: begin
				div_num = NW'(el_idle);
				div_den = cyc_len;
			end
			default: begin
				div_num = (NW'(into_q) << F) + NW'(thump_len >> 1);
				div_den = thump_len;
			end
		endcase
	end
	assign div_start = cmd.div_start;

	icca_div #(.NUM_W(NW), .DEN_W(16)) u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .num(div_num), .den(div_den),
		.busy(div_busy), .quo(div_quo), .rem(div_rem)
	);

	// divider holds the fraction until the next division starts
	assign x_frac = FW'(div_quo);

	// one product per step
	logic [2*FW+9:0] prod;
	logic [FW-1:0]   rnd;
	logic [7:0]      ca, cb, cm;
	logic [8:0]      inv;
	logic [16:0]     chsum;
	logic [7:0]      chq;
	logic [7:0]      span;

	assign inv = 9'd255 - t_q;
	assign span = high_q - low_q;

	always_comb begin
		ca = from_q[23:16];
		cb = target_q[23:16];
		cm = target_q[23:16];
		case (cmd.op)
			icca_pkg::OP_MIX_G, icca_pkg::OP_DIM_G: begin
				ca = from_q[15:8]; cb = target_q[15:8]; cm = target_q[15:8];
			end
			icca_pkg::OP_MIX_B, icca_pkg::OP_DIM_B: begin
				ca = from_q[7:0]; cb = target_q[7:0]; cm = target_q[7:0];
			end
			default: ;
		endcase
	end

	always_comb begin
		prod  = '0;
		chsum = '0;
		case (cmd.op)
			icca_pkg::OP_X2:  prod = ($bits(prod))'(x_frac) * ($bits(prod))'(x_frac);
			icca_pkg::OP_S:   prod = ($bits(prod))'(x2_q)
				* ($bits(prod))'(3 * {2'b0, ONE} - 2 * {2'b0, x_frac});
			icca_pkg::OP_T:   prod = ($bits(prod))'(s_q) * ($bits(prod))'(255);
			icca_pkg::OP_Q:   prod = ($bits(prod))'(x_frac) * ($bits(prod))'(ONE - x_frac);
			icca_pkg::OP_BRIGHT: prod = ($bits(prod))'(span) * ($bits(prod))'(acc_q);
			icca_pkg::OP_MIX_R, icca_pkg::OP_MIX_G, icca_pkg::OP_MIX_B:
				chsum = 17'(ca) * 17'(inv) + 17'(cb) * 17'(t_q);
			default:
				chsum = 17'(cm) * 17'(bright_q);
		endcase
	end
	assign rnd = FW'((prod + ($bits(prod))'(HALF)) >> F);
	assign chq = 8'((25'(chsum) * 25'd257 + 25'd257) >> 16);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fade_time_q <= 16'd400;
			delay_q     <= 32'd60000;
			cycle_q     <= 16'd1200;
			thump_q     <= 16'd120;
			gap_q       <= 16'd80;
			low_q       <= 8'd60;
			high_q      <= 8'd255;
			def_q       <= 24'd255;
			from_q      <= 24'd255;
			target_q    <= 24'd255;
			start_q     <= '0;
			last_q      <= '0;
			active_q    <= 1'b0;
			tinted_q    <= 1'b0;
			cached_q    <= '0;
			cvalid_q    <= 1'b0;
			send_q      <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					4'(icca_pkg::REG_FADE_TIME):  fade_time_q <= cfg_data[15:0];
					4'(icca_pkg::REG_ATTR_DELAY): delay_q     <= cfg_data;
					4'(icca_pkg::REG_ATTR_CYCLE): cycle_q     <= cfg_data[15:0];
					4'(icca_pkg::REG_THUMP):      thump_q     <= cfg_data[15:0];
					4'(icca_pkg::REG_THUMP_GAP):  gap_q       <= cfg_data[15:0];
					4'(icca_pkg::REG_ATTR_LOW):   low_q       <= cfg_data[7:0];
					4'(icca_pkg::REG_ATTR_HIGH):  high_q      <= cfg_data[7:0];
					4'(icca_pkg::REG_DEF_COLOR):  def_q       <= cfg_data[23:0];
					default: ;
				endcase
			end
			if (cmd.commit) begin
				case (act_q)
					icca_pkg::ACT_TICK: begin
						if (active_q && el_fade >= 32'(fade_len)) begin
							active_q <= 1'b0;
							from_q   <= target_q;
						end
						send_q   <= !(cvalid_q && color_q == cached_q);
						cached_q <= color_q;
						cvalid_q <= 1'b1;
					end
					icca_pkg::ACT_SET, icca_pkg::ACT_CLEAR: begin
						last_q <= now_q;
						tinted_q <= (act_q == icca_pkg::ACT_SET) && (tint_q != def_q);
						if (active_q || tint_q != target_q) begin
							from_q   <= color_q;
							target_q <= tint_q;
							start_q  <= now_q;
							active_q <= 1'b1;
						end
					end
					default: begin
						from_q   <= target_q;
						active_q <= 1'b0;
						last_q   <= now_q;
						cvalid_q <= 1'b0;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			act_q  <= in_data.action;
			tint_q <= (in_data.action == icca_pkg::ACT_CLEAR) ? def_q : in_data.tint_color;
			now_q  <= in_data.now_ms;
		end
		if (cmd.beat_eval) begin
			// divider holds phase remainder here
			phase_q <= div_rem;
			if ({1'b0, div_rem} < {1'b0, thump_len}) into_q <= div_rem;
			else into_q <= 16'(17'(div_rem) - second);
		end
		if (cmd.latch) begin
			attr_q  <= 1'b0;
			color_q <= target_q;
			bright_q <= high_q;
		end else if (cmd.beat_eval) begin
			attr_q <= 1'b1;
		end
		if (cmd.op_en) begin
			case (cmd.op)
				icca_pkg::OP_X2:     x2_q <= rnd;
				icca_pkg::OP_S:      s_q <= rnd;
				icca_pkg::OP_T:      t_q <= (rnd > FW'(255)) ? 9'd255 : 9'(rnd);
				icca_pkg::OP_MIX_R:  mix_q[15:8] <= chq;
				icca_pkg::OP_MIX_G:  mix_q[7:0]  <= chq;
				icca_pkg::OP_MIX_B:  color_q <= {mix_q, chq};
				icca_pkg::OP_Q:      acc_q <= ONE - FW'(((prod << 2)
					+ ($bits(prod))'(HALF)) >> F);
				icca_pkg::OP_BRIGHT: bright_q <= low_q + 8'(rnd);
				icca_pkg::OP_DIM_R:  color_q[23:16] <= chq;
				icca_pkg::OP_DIM_G:  color_q[15:8]  <= chq;
				default:             color_q[7:0]   <= chq;
			endcase
		end
	end

	assign sts.action      = act_q;
	assign sts.fade_active = active_q;
	assign sts.fade_done   = el_fade >= 32'(fade_len);
	assign sts.attr        = !tinted_q && (el_idle >= delay_q);
	assign sts.div_busy    = div_busy;
	assign sts.in_thump    = (high_q > low_q) && ((phase_q < thump_len) ||
		(17'(phase_q) >= second && 18'(phase_q) < 18'(second) + 18'(thump_len)));

	assign result.shown_color = (act_q == icca_pkg::ACT_TICK) ? color_q : cached_q;
	assign result.transmit    = (act_q == icca_pkg::ACT_TICK) && send_q;
	assign result.fading      = active_q;
	assign result.attracting  = attr_q;
endmodule

// ----- hdl/icca_ctrl.sv -----
// Controller: sequences latch, divider, multiply steps, commit and output.
// Depends on icca_pkg.
module icca_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	input  icca_pkg::icca_sts_t sts,
	output icca_pkg::icca_cmd_t cmd
);
	typedef enum logic [3:0] {
		S_IDLE, S_DECIDE, S_DIV, S_STEP, S_BEAT, S_COMMIT, S_OUT
	} state_t;

	state_t state_q;
	icca_pkg::op_t op_q;
	icca_pkg::div_sel_t sel_q;
	logic div_wait_q;
	logic thump_done_q;

	assign in_ready = (state_q == S_IDLE);
	assign out_valid = (state_q == S_OUT);

	always_comb begin
		cmd = '0;
		cmd.latch = in_valid && in_ready;
		cmd.div_sel = sel_q;
		cmd.op = op_q;
		cmd.op_en = (state_q == S_STEP);
		cmd.commit = (state_q == S_COMMIT);
		cmd.div_start = (state_q == S_DIV) && !div_wait_q;
		cmd.beat_eval = (state_q == S_BEAT);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			op_q <= icca_pkg::OP_X2;
			sel_q <= icca_pkg::DIV_FADE;
			div_wait_q <= 1'b0;
			thump_done_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: if (in_valid) state_q <= S_DECIDE;
				S_DECIDE: begin
					if (sts.fade_active && !sts.fade_done) begin
						sel_q <= icca_pkg::DIV_FADE;
						state_q <= S_DIV;
					end else if (sts.action == icca_pkg::ACT_TICK && !sts.fade_active
						&& sts.attr) begin
						sel_q <= icca_pkg::DIV_CYCLE;
						state_q <= S_DIV;
					end else begin
						state_q <= S_COMMIT;
					end
				end
				S_DIV: begin
					if (!div_wait_q) begin
						div_wait_q <= 1'b1;
					end else if (!sts.div_busy) begin
						div_wait_q <= 1'b0;
						if (sel_q == icca_pkg::DIV_CYCLE) state_q <= S_BEAT;
						else begin
							op_q <= (sel_q == icca_pkg::DIV_FADE) ? icca_pkg::OP_X2
								: icca_pkg::OP_Q;
							state_q <= S_STEP;
						end
					end
				end
				S_BEAT: begin
					sel_q <= icca_pkg::DIV_THUMP;
					state_q <= S_STEP;
					op_q <= icca_pkg::OP_DIM_R;
					thump_done_q <= 1'b0;
				end
				S_STEP: begin
					if (sel_q == icca_pkg::DIV_THUMP && op_q == icca_pkg::OP_DIM_R
						&& sts.in_thump && !thump_done_q) begin
						thump_done_q <= 1'b1;
						state_q <= S_DIV;
					end else if (op_q == icca_pkg::OP_MIX_B || op_q == icca_pkg::OP_DIM_B) begin
						state_q <= S_COMMIT;
					end else begin
						op_q <= icca_pkg::op_t'(op_q + 1'b1);
					end
				end
				S_COMMIT: state_q <= S_OUT;
				S_OUT: if (out_ready) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

// ----- hdl/idle_color_crossfade_attract_top.sv -----
// Idle color engine top level: smoothstep RGB crossfade with heartbeat dimming.
// Depends on icca_pkg, icca_ctrl, icca_datapath.
//
// Usage:
//   Input channel in_valid/in_ready/in_data carries one request: action,
//   tint color and a millisecond timestamp. Output channel
//   out_valid/out_ready/out_data returns exactly one result per request.
//   Configuration registers are written through cfg_we/cfg_index/cfg_data
//   while the block is idle; indexes past the list are ignored.
//   Arithmetic runs on the bit-serial divider: one division when a running
//   fade is mixed, one for a heartbeat tick outside a thump and two for a
//   tick inside one; a request with no arithmetic goes straight from
//   S_DECIDE to S_COMMIT and S_OUT.
//   One request is in flight at a time; in_ready rises the cycle after the
//   result is taken, so a stalled receiver holds the block.
//   Reset loads register defaults and clears all fade and cache state.
module idle_color_crossfade_attract_top #(
	parameter int FRACTION_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  icca_pkg::in_req_t             in_data,
	output logic                          out_valid,
	input  logic                          out_ready,
	output icca_pkg::out_req_t            out_data,
	input  logic                          cfg_we,
	input  logic [icca_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [icca_pkg::CFG_DATA_W-1:0]  cfg_data
);
	icca_pkg::icca_cmd_t cmd;
	icca_pkg::icca_sts_t sts;

	icca_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.out_valid(out_valid), .out_ready(out_ready), .sts(sts), .cmd(cmd)
	);

	icca_datapath #(.FRACTION_BITS(FRACTION_BITS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .in_data(in_data), .cmd(cmd), .sts(sts), .result(out_data)
	);
endmodule

// ----- tb/sv/idle_color_crossfade_attract_top_tb.sv -----
// Testbench for idle_color_crossfade_attract_top: directed and random requests against a
// built-in predictor of crossfade, heartbeat dimming and frame caching.
// Depends on icca_pkg and the top-level RTL.
`timescale 1ns / 1ps

module idle_color_crossfade_attract_top_tb;

	localparam int FB = 16;
	localparam longint unsigned ONE = 64'd1 << FB;
	localparam longint unsigned HALF = ONE >> 1;
	localparam int CYCLE_LIMIT = 3000000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	icca_pkg::in_req_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	icca_pkg::out_req_t out_data;
	logic cfg_we = 1'b0;
	logic [icca_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
	logic [icca_pkg::CFG_DATA_W-1:0] cfg_data = '0;

	icca_pkg::in_req_t pending_reqs[$];
	icca_pkg::out_req_t expected_frames[$];
	logic req_taken = 1'b0;
	int send_idle = 0;
	int recv_idle = 0;
	int errors = 0;
	int cycles = 0;
	int n_frames = 0;
	int n_attract = 0;
	int n_fade = 0;

	// mirrored registers and engine state
	logic [31:0] r_fade_time, r_delay, r_cycle, r_thump, r_gap, r_low, r_high, r_default;
	logic [31:0] s_from, s_target, s_start, s_activity, s_cached;
	logic s_active, s_tinted, s_cache_ok;

	logic [31:0] t_now;
	logic [23:0] last_tint;

	idle_color_crossfade_attract_top u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	function automatic logic [31:0] ch(logic [31:0] c, int sh);
		return (c >> sh) & 32'hFF;
	endfunction

	function automatic logic [31:0] dim_rgb(logic [31:0] c, logic [31:0] b);
		return ((ch(c, 16) * b / 255) << 16) | ((ch(c, 8) * b / 255) << 8) | (ch(c, 0) * b / 255);
	endfunction

	function automatic logic [31:0] blend_rgb(logic [31:0] a, logic [31:0] b, logic [31:0] t);
		logic [31:0] inv;
		inv = 255 - t;
		return (((ch(a, 16) * inv + ch(b, 16) * t) / 255) << 16) |
			(((ch(a, 8) * inv + ch(b, 8) * t) / 255) << 8) |
			((ch(a, 0) * inv + ch(b, 0) * t) / 255);
	endfunction

	function automatic longint unsigned q_ratio(logic [31:0] num, logic [31:0] den);
		return ((longint'(num) << FB) + den / 2) / den;
	endfunction

	function automatic logic [31:0] fade_length();
		return (r_fade_time == 0) ? 32'd1 : r_fade_time;
	endfunction

	function automatic logic [31:0] smooth_blend(logic [31:0] e);
		longint unsigned x, x2, s, t;
		x = q_ratio(e, fade_length());
		x2 = (x * x + HALF) >> FB;
		s = (x2 * (3 * ONE - 2 * x) + HALF) >> FB;
		t = (s * 255 + HALF) >> FB;
		if (t > 255)
			t = 255;
		return blend_rgb(s_from, s_target, t[31:0]);
	endfunction

	function automatic logic [31:0] heartbeat_level(logic [31:0] ph);
		logic [31:0] m, second, into;
		longint unsigned x, q, dip;
		m = (r_thump == 0) ? 32'd1 : r_thump;
		second = m + r_gap;
		if (r_high <= r_low)
			return r_high;
		if (ph < m)
			into = ph;
		else if (ph >= second && ph < second + m)
			into = ph - second;
		else
			return r_high;
		x = q_ratio(into, m);
		q = (4 * x * (ONE - x) + HALF) >> FB;
		dip = ONE - q;
		return r_low + 32'(((longint'(r_high - r_low)) * dip + HALF) >> FB);
	endfunction

	function automatic void begin_fade(logic [31:0] color, logic [31:0] now);
		logic [31:0] e;
		s_activity = now;
		if (!s_active && color == s_target)
			return;
		if (s_active) begin
			e = now - s_start;
			s_from = (e >= fade_length()) ? s_target : smooth_blend(e);
		end else begin
			s_from = s_target;
		end
		s_target = color;
		s_start = now;
		s_active = 1'b1;
	endfunction

	function automatic icca_pkg::out_req_t predict_frame(icca_pkg::in_req_t r);
		icca_pkg::out_req_t o;
		logic [31:0] color, e, cyc;
		logic send, attr;
		send = 1'b0;
		attr = 1'b0;
		if (r.action == icca_pkg::ACT_TICK) begin
			if (!s_active) begin
				attr = !s_tinted && (r.now_ms - s_activity) >= r_delay;
				if (attr) begin
					cyc = (r_cycle == 0) ? 32'd1 : r_cycle;
					color = dim_rgb(s_target, heartbeat_level((r.now_ms - s_activity) % cyc));
				end else begin
					color = s_target;
				end
			end else begin
				e = r.now_ms - s_start;
				if (e >= fade_length()) begin
					s_active = 1'b0;
					s_from = s_target;
					color = s_target;
				end else begin
					color = smooth_blend(e);
				end
			end
			send = !(s_cache_ok && color == s_cached);
			s_cached = color;
			s_cache_ok = 1'b1;
		end else begin
			if (r.action == icca_pkg::ACT_SET) begin
				s_tinted = (r.tint_color != r_default[23:0]);
				begin_fade({8'd0, r.tint_color}, r.now_ms);
			end else if (r.action == icca_pkg::ACT_CLEAR) begin
				s_tinted = 1'b0;
				begin_fade(r_default, r.now_ms);
			end else begin
				s_from = s_target;
				s_active = 1'b0;
				s_activity = r.now_ms;
				s_cache_ok = 1'b0;
			end
			color = s_cached;
		end
		o.shown_color = color[23:0];
		o.transmit = send;
		o.fading = s_active;
		o.attracting = attr;
		return o;
	endfunction

	// drive requests and receiver backpressure
	always @(negedge clk) begin
		if (arst_n) begin
			if (!in_valid || req_taken) begin
				if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle) begin
					in_valid <= 1'b1;
					in_data <= pending_reqs.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
			out_ready <= ($urandom_range(99) >= recv_idle);
		end
	end

	// predict on each accepted request, check each accepted result
	always @(posedge clk) begin
		icca_pkg::out_req_t want;
		req_taken <= in_valid && in_ready;
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout at %0t", $time);
			$display("RESULT: ERROR");
			$finish;
		end
		if (arst_n && in_valid && in_ready) begin
			want = predict_frame(in_data);
			expected_frames.push_back(want);
			if (in_data.action == icca_pkg::ACT_TICK) begin
				n_frames++;
				if (want.attracting) n_attract++;
				if (want.fading) n_fade++;
			end
		end
		if (arst_n && out_valid && out_ready) begin
			if (expected_frames.size() == 0) begin
				errors++;
				$display("%0t unexpected result %h", $time, out_data);
			end else begin
				want = expected_frames.pop_front();
				if (out_data.shown_color !== want.shown_color) begin
					errors++;
					$display("%0t shown_color exp %h got %h", $time, want.shown_color,
						out_data.shown_color);
				end
				if (out_data.transmit !== want.transmit) begin
					errors++;
					$display("%0t transmit exp %b got %b", $time, want.transmit, out_data.transmit);
				end
				if (out_data.fading !== want.fading) begin
					errors++;
					$display("%0t fading exp %b got %b", $time, want.fading, out_data.fading);
				end
				if (out_data.attracting !== want.attracting) begin
					errors++;
					$display("%0t attracting exp %b got %b", $time, want.attracting,
						out_data.attracting);
				end
			end
		end
	end

	task automatic write_reg(logic [icca_pkg::CFG_INDEX_W-1:0] idx, logic [31:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			icca_pkg::REG_FADE_TIME: r_fade_time = val & 32'hFFFF;
			icca_pkg::REG_ATTR_DELAY: r_delay = val;
			icca_pkg::REG_ATTR_CYCLE: r_cycle = val & 32'hFFFF;
			icca_pkg::REG_THUMP: r_thump = val & 32'hFFFF;
			icca_pkg::REG_THUMP_GAP: r_gap = val & 32'hFFFF;
			icca_pkg::REG_ATTR_LOW: r_low = val & 32'hFF;
			icca_pkg::REG_ATTR_HIGH: r_high = val & 32'hFF;
			icca_pkg::REG_DEF_COLOR: r_default = val & 32'hFFFFFF;
			default: ;
		endcase
	endtask

	task automatic write_all(logic [31:0] ft, logic [31:0] dl, logic [31:0] cy, logic [31:0] th,
			logic [31:0] gp, logic [31:0] lo, logic [31:0] hi, logic [31:0] dc);
		write_reg(icca_pkg::REG_FADE_TIME, ft);
		write_reg(icca_pkg::REG_ATTR_DELAY, dl);
		write_reg(icca_pkg::REG_ATTR_CYCLE, cy);
		write_reg(icca_pkg::REG_THUMP, th);
		write_reg(icca_pkg::REG_THUMP_GAP, gp);
		write_reg(icca_pkg::REG_ATTR_LOW, lo);
		write_reg(icca_pkg::REG_ATTR_HIGH, hi);
		write_reg(icca_pkg::REG_DEF_COLOR, dc);
		write_reg(4'(8 + $urandom_range(7)), $urandom);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic add_req(logic [1:0] act, logic [23:0] tint, logic [31:0] now);
		icca_pkg::in_req_t r;
		r.action = act;
		r.tint_color = tint;
		r.now_ms = now;
		pending_reqs.push_back(r);
	endtask

	task automatic drain();
		while (pending_reqs.size() != 0 || in_valid || expected_frames.size() != 0)
			@(posedge clk);
		repeat (150) @(posedge clk);
	endtask

	task automatic add_random(int n, logic [31:0] span);
		int r;
		logic [23:0] c;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(99);
			c = $urandom;
			if (r < 70) begin
				t_now += ($urandom_range(9) == 0) ? $urandom_range(span) : $urandom_range(40);
				add_req(icca_pkg::ACT_TICK, c, t_now);
			end else if (r < 80) begin
				case ($urandom_range(3))
					0: c = r_default[23:0];
					1: c = last_tint;
					default: last_tint = c;
				endcase
				add_req(icca_pkg::ACT_SET, c, t_now);
			end else if (r < 87) begin
				add_req(icca_pkg::ACT_CLEAR, c, t_now);
			end else if (r < 94) begin
				add_req(icca_pkg::ACT_IDLE, c, t_now);
			end else begin
				add_req(2'($urandom), c, $urandom);
			end
		end
	endtask

	task automatic random_phase(int n, logic [31:0] span);
		add_random(n / 2, span);
		drain();
		add_random(n - n / 2, span);
		drain();
	endtask

	initial begin
		r_fade_time = 400;
		r_delay = 60000;
		r_cycle = 1200;
		r_thump = 120;
		r_gap = 80;
		r_low = 60;
		r_high = 255;
		r_default = 255;
		s_from = 255;
		s_target = 255;
		s_start = 0;
		s_active = 0;
		s_tinted = 0;
		s_activity = 0;
		s_cached = 0;
		s_cache_ok = 0;
		last_tint = 24'hFF0000;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset configuration: fade, finish, unchanged tint, heartbeat thumps, wrap
		add_req(icca_pkg::ACT_TICK, 24'h000000, 32'd0);
		add_req(icca_pkg::ACT_TICK, 24'hFFFFFF, 32'd0);
		add_req(icca_pkg::ACT_SET, 24'hFF0000, 32'd10);
		add_req(icca_pkg::ACT_TICK, 24'h0, 32'd10);
		add_req(icca_pkg::ACT_TICK, 24'h0, 32'd210);
		add_req(icca_pkg::ACT_TICK, 24'h0, 32'd410);
		add_req(icca_pkg::ACT_SET, 24'hFF0000, 32'd500);
		add_req(icca_pkg::ACT_CLEAR, 24'h0, 32'd600);
		add_req(icca_pkg::ACT_TICK, 24'h0, 32'd700);
		add_req(icca_pkg::ACT_SET, 24'h0000FF, 32'd800);
		add_req(icca_pkg::ACT_TICK, 24'h0, 32'd1300);
		add_req(icca_pkg::ACT_IDLE, 24'h0, 32'd1400);
		add_req(icca_pkg::ACT_TICK, 24'h0, 32'd1400);
		add_req(icca_pkg::ACT_TICK, 24'h0, 32'd61400);
		add_req(icca_pkg::ACT_TICK, 24'h0, 32'd61460);
		add_req(icca_pkg::ACT_TICK, 24'h0, 32'd61660);
		add_req(icca_pkg::ACT_TICK, 24'h0, 32'd61700);
		add_req(icca_pkg::ACT_SET, 24'hFFFFFF, 32'hFFFFFFF0);
		add_req(icca_pkg::ACT_TICK, 24'h0, 32'h00000100);
		add_req(icca_pkg::ACT_IDLE, 24'h0, 32'h00000120);
		add_req(icca_pkg::ACT_TICK, 24'h0, 32'hFFFFFFFF);
		add_req(icca_pkg::ACT_SET, 24'h000000, 32'h00000200);
		add_req(icca_pkg::ACT_TICK, 24'h0, 32'h00000300);
		add_req(icca_pkg::ACT_CLEAR, 24'h0, 32'h00000400);
		drain();

		t_now = 32'hFFFFFF00;
		for (int ph = 0; ph < 6; ph++) begin
			if (ph < 2) begin
				send_idle = 14;
				recv_idle = 69;
			end else if (ph < 4) begin
				send_idle = 69;
				recv_idle = 14;
			end else begin
				send_idle = 0;
				recv_idle = 0;
			end
			case (ph)
				0: write_all(0, 0, 0, 0, 0, 0, 255, 32'hFFFFFF);
				1: write_all(32'hFFFF, 32'hFFFFFFFF, 32'hFFFF, 32'hFFFF, 32'hFFFF, 255, 0, 0);
				2: write_all(37, 20, 300, 40, 30, 10, 200, $urandom);
				default: write_all($urandom_range(100), $urandom_range(100),
					$urandom_range(400), $urandom_range(100), $urandom_range(100),
					$urandom_range(255), $urandom_range(255), $urandom);
			endcase
			random_phase(305, (ph == 1) ? 32'hFFFFFFFF : 32'd600);
		end

		$display("%0d ticks checked, %0d during a crossfade, %0d in heartbeat dimming",
			n_frames, n_fade, n_attract);
		$display("six register settings with directed and random requests, %0d mismatches",
			errors);
		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

// ----- sim.f -----
hdl/icca_pkg.sv
hdl/icca_div.sv
hdl/icca_datapath.sv
hdl/icca_ctrl.sv
hdl/idle_color_crossfade_attract_top.sv
tb/sv/idle_color_crossfade_attract_top_tb.sv
